[sv/lbc_pkg.sv]
// lbc_pkg: shared types, codes and constants of the LRU block cache.
// Used by lbc_ctrl, lbc_datapath and lru_block_cache_top.
`timescale 1ns / 1ps
package lbc_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int BLOCK_WORDS_DEF = 8;
  localparam int KEY_BITS_DEF = 64;
  localparam int CAP_W = 5;
  localparam int STATUS_W = 3;
  localparam int WIDX_W = 3;
  localparam int WORD_W = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GET_MISS = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GET_HIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PUT_INS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PUT_EVICT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUT_PRESENT = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic lookup;     // register input beat, start tag match
    logic get_hit;    // make hit slot recent (get)
    logic put_hit;    // make hit slot recent, arm discard
    logic put_alloc;  // allocate (with eviction when full)
    logic put_later;  // write a later put word
    logic rd_word;    // issue block read for current word count
    logic out_load;   // load output register
  } lbc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic is_put;
    logic word0;
    logic full;
  } lbc_sts_t;
endpackage

[sv/lbc_datapath.sv]
// lbc_datapath: tag/age registers, block memory, output register.
// Depends on lbc_pkg; sequenced by lbc_ctrl.
`timescale 1ns / 1ps
module lbc_datapath #(
  parameter int ENTRIES = lbc_pkg::ENTRIES_DEF,
  parameter int BLOCK_WORDS = lbc_pkg::BLOCK_WORDS_DEF,
  parameter int KEY_BITS = lbc_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_func,
  input  logic [63:0]                   in_key,
  input  logic [lbc_pkg::WIDX_W-1:0]    in_widx,
  input  logic [lbc_pkg::WORD_W-1:0]    in_word,
  input  logic [lbc_pkg::CAP_W-1:0]     capacity,
  input  lbc_pkg::lbc_cmd_t             cmd,
  output lbc_pkg::lbc_sts_t             sts,
  output logic [lbc_pkg::STATUS_W-1:0]  out_status,
  output logic [lbc_pkg::WORD_W-1:0]    out_word,
  output logic                          out_last,
  output logic                          words_done
);
  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int DEPTH = ENTRIES * BLOCK_WORDS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ENTRIES-1:0]         valid_r;
  logic [KEY_BITS-1:0]        tag_r [ENTRIES];
  logic [SW-1:0]              age_r [ENTRIES];
  logic [lbc_pkg::WORD_W-1:0] mem [DEPTH];
  logic [FW-1:0]              fill_r;
  logic [SW-1:0]              put_slot_r;
  logic                       discard_r;
  logic                       func_r;
  logic [KEY_BITS-1:0]        key_r;
  logic [lbc_pkg::WIDX_W-1:0] widx_r;
  logic [lbc_pkg::WORD_W-1:0] word_r;
  logic [ENTRIES-1:0]         match_r;
  logic [BW:0]                wcnt_r;
  logic [lbc_pkg::WORD_W-1:0] rdata_r;
  logic [lbc_pkg::STATUS_W-1:0] status_r;
  logic                       last_r;

  logic [SW-1:0] hit_slot, old_slot, free_sl, alloc_slot;
  logic          any_old;
  logic [FW-1:0] eff_cap;
  logic          full;

  // match is registered from the input beat, so the compare sits alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
    end else if (cmd.lookup) begin
      func_r <= in_func;
      key_r  <= in_key[KEY_BITS-1:0];
      widx_r <= in_widx;
      word_r <= in_word;
      for (int i = 0; i < ENTRIES; i++)
        match_r[i] <= valid_r[i] && (tag_r[i] == in_key[KEY_BITS-1:0]);
    end
  end

  always_comb begin
    hit_slot = '0;
    old_slot = '0;
    free_sl = '0;
    any_old = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hit_slot = SW'(i);
      if (!valid_r[i]) free_sl = SW'(i);
    end
    // oldest valid entry has age fill-1 (ranks are a permutation)
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && !any_old && (FW'(age_r[i]) + FW'(1) == fill_r)) begin
        old_slot = SW'(i);
        any_old = 1'b1;
      end
    end
    if (capacity == '0) eff_cap = FW'(1);
    else if (32'(capacity) > ENTRIES) eff_cap = FW'(ENTRIES);
    else eff_cap = FW'(capacity);
    full = (fill_r >= eff_cap);
    alloc_slot = full ? old_slot : free_sl;
  end

  assign sts.hit = |match_r;
  assign sts.is_put = func_r;
  assign sts.word0 = (widx_r == '0);
  assign sts.full = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r <= '0;
      put_slot_r <= '0;
      discard_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= '0;
    end else if (cmd.get_hit || cmd.put_hit) begin
      for (int i = 0; i < ENTRIES; i++)
        if (valid_r[i] && !match_r[i] && age_r[i] < age_r[hit_slot])
          age_r[i] <= age_r[i] + SW'(1);
      age_r[hit_slot] <= '0;
      if (cmd.put_hit) begin
        put_slot_r <= hit_slot;
        discard_r <= 1'b1;
      end
    end else if (cmd.put_alloc) begin
      for (int i = 0; i < ENTRIES; i++)
        if (valid_r[i]) age_r[i] <= age_r[i] + SW'(1);
      age_r[alloc_slot] <= '0;
      valid_r[alloc_slot] <= 1'b1;
      if (!(full && any_old)) fill_r <= fill_r + FW'(1);
      put_slot_r <= alloc_slot;
      discard_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_alloc) tag_r[alloc_slot] <= key_r;
  end

  // block memory: one write port, one registered read port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  always_comb begin
    we = 1'b0;
    waddr = AW'(alloc_slot) * AW'(BLOCK_WORDS);
    if (cmd.put_alloc) we = 1'b1;
    else if (cmd.put_later && !discard_r && 32'(widx_r) < BLOCK_WORDS) begin
      we = 1'b1;
      waddr = AW'(put_slot_r) * AW'(BLOCK_WORDS) + AW'(widx_r);
    end
    raddr = AW'(hit_slot) * AW'(BLOCK_WORDS) + AW'(wcnt_r[BW-1:0]);
  end

  // read data holds until the next word is issued
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= word_r;
    if (cmd.rd_word) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.lookup) wcnt_r <= '0;
    else if (cmd.rd_word) wcnt_r <= wcnt_r + (BW+1)'(1);
  end
  assign words_done = (32'(wcnt_r) == BLOCK_WORDS);

  logic rd_d_r;
  logic [BW:0] wcnt_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rd_d_r <= 1'b0;
    else rd_d_r <= cmd.rd_word;
    wcnt_d_r <= wcnt_r;
  end

  // status for the single-result cases; stream words when read data returns
  always_ff @(posedge clk) begin
    if (rd_d_r) begin
      status_r <= lbc_pkg::ST_GET_HIT;
      last_r <= (32'(wcnt_d_r) + 1 == BLOCK_WORDS);
    end else if (cmd.out_load) begin
      last_r <= 1'b1;
      if (!func_r) status_r <= lbc_pkg::ST_GET_MISS;
      else if (|match_r) status_r <= lbc_pkg::ST_PUT_PRESENT;
      else if (full) status_r <= lbc_pkg::ST_PUT_EVICT;
      else status_r <= lbc_pkg::ST_PUT_INS;
    end
  end

  assign out_status = status_r;
  assign out_word = (status_r == lbc_pkg::ST_GET_HIT) ? rdata_r : '0;
  assign out_last = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= ENTRIES) else $error("fill count above entries");
  a_fill_pop: assert property (@(posedge clk) disable iff (!rst_n)
    FW'($countones(valid_r)) == fill_r) else $error("fill count mismatch");
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r)) else $error("multiple tag matches");
endmodule

[sv/lbc_ctrl.sv]
// lbc_ctrl: controller state machine of the LRU block cache.
// Depends on lbc_pkg; drives lbc_datapath by command struct.
`timescale 1ns / 1ps
module lbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  lbc_pkg::lbc_sts_t  sts,
  input  logic               words_done,
  output lbc_pkg::lbc_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RD    = 6'b000100,
    S_WAIT  = 6'b001000,
    S_OUT   = 6'b010000,
    S_SNGL  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   out_fire;

  assign out_fire = ovalid_r && out_tready;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.lookup = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.is_put) begin
          if (sts.hit) begin
            cmd.rd_word = 1'b1;
            state_nxt = S_RD;
          end else begin
            cmd.out_load = 1'b1;
            state_nxt = S_SNGL;
          end
        end else if (sts.word0) begin
          cmd.out_load = 1'b1;
          if (sts.hit) cmd.put_hit = 1'b1;
          else cmd.put_alloc = 1'b1;
          state_nxt = S_SNGL;
        end else begin
          cmd.put_later = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SNGL: begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        // read data lands this cycle in the output register
        ovalid_nxt = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_fire) begin
          if (words_done) begin
            cmd.get_hit = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_word = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready) |-> (state_r == S_IDLE && !ovalid_r)) else $error("accept while busy");
  a_rd_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> ovalid_r) else $error("read word not presented");
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
endmodule

[sv/lru_block_cache_top.sv]
// lru_block_cache_top: fully associative LRU block cache, top level.
// Instantiates lbc_ctrl and lbc_datapath; uses lbc_pkg.
`timescale 1ns / 1ps
// Usage:
//   Input beats (in_*) carry get or put requests: tuser = func, tdata = key,
//   word_index, data_word. A put sends one beat per block word, word 0 first.
//   Result beats (out_*) carry status and read_word in tdata, tlast marks
//   the final result of one input beat.
//   cfg_we/cfg_wdata write the capacity register (idle only).
//   A miss or put word 0 is registered, matched, then its result is loaded
//   into the output register; a later put word is written and gives no
//   result. A get hit streams BLOCK_WORDS beats, each made by a block memory
//   read, then the output register.
//   One item is in flight at a time; in_tready is low while it works or a
//   result waits. When out_tready is low the result holds in the output
//   register and the sequence pauses.
//   Reset clears valid bits, ages, fill count and capacity (to 16); tag and
//   block memories are not cleared.
module lru_block_cache_top #(
  parameter int ENTRIES = lbc_pkg::ENTRIES_DEF,
  parameter int BLOCK_WORDS = lbc_pkg::BLOCK_WORDS_DEF,
  parameter int KEY_BITS = lbc_pkg::KEY_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // key[63:0], word_index[66:64], data_word[130:67]
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // status[2:0], read_word[66:3]
  output logic         out_tlast,  // last
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata   // capacity
);
  logic [lbc_pkg::CAP_W-1:0] cap_r;
  lbc_pkg::lbc_cmd_t cmd;
  lbc_pkg::lbc_sts_t sts;
  logic [lbc_pkg::STATUS_W-1:0] st;
  logic [lbc_pkg::WORD_W-1:0] rw;
  logic words_done;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= lbc_pkg::CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  lbc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .words_done, .cmd
  );

  lbc_datapath #(.ENTRIES(ENTRIES), .BLOCK_WORDS(BLOCK_WORDS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk, .rst_n,
    .in_func(in_tuser), .in_key(in_tdata[63:0]), .in_widx(in_tdata[66:64]),
    .in_word(in_tdata[130:67]), .capacity(cap_r), .cmd, .sts,
    .out_status(st), .out_word(rw), .out_last(out_tlast), .words_done
  );

  assign out_tdata = {5'd0, rw, st};
endmodule
